### hw/rtl/hsv_pkg.sv
// Package for the HSV to RGB pixel color block.
// Holds the fixed-point constants, the queue item type and the default queue depth.
// No dependencies.
package hsv_pkg;

    localparam int HUE_W = 12;
    localparam int FRAC_W = 8;
    localparam int PCT_W = 7;
    localparam int WEIGHT_W = 10;
    localparam int NUM_CH = 3;

    localparam int HUE_FULL = 3600;
    localparam int HUE_PAIR = 1200;
    localparam int HUE_HALF = 600;
    localparam int FRAC_ONE = 255;
    localparam int PCT_ONE = 100;
    localparam int INNER_FULL = FRAC_ONE * HUE_HALF;

    localparam logic [63:0] CHAN_DENOM = 64'(FRAC_ONE) * 64'(HUE_HALF) * 64'(PCT_ONE);
    localparam int DROP_SHIFT = 14;
    localparam int RECIP_SHIFT = 24;
    localparam logic [14:0] RECIP = 15'((64'd1 << (DROP_SHIFT + RECIP_SHIFT)) / CHAN_DENOM);

    localparam int CH_RED = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 2;

    localparam logic [PCT_W-1:0] BRIGHT_RESET = 7'd100;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [NUM_CH-1:0][WEIGHT_W-1:0] weight;
        logic [FRAC_W-1:0]               sat;
        logic [FRAC_W-1:0]               val;
    } t_item;

endpackage

### hw/rtl/hsv_front.sv
// Front end of the HSV to RGB block: wraps the hue and picks each channel's weight.
// Depends on hsv_pkg.
module hsv_front
    import hsv_pkg::*;
(
    input  logic [HUE_W-1:0]  i_hue_tenths,
    input  logic [FRAC_W-1:0] i_saturation,
    input  logic [FRAC_W-1:0] i_value_level,
    output t_item             o_item
);

    typedef enum logic [2:0] {
        SEC_RED_UP,
        SEC_GREEN_DOWN,
        SEC_GREEN_UP,
        SEC_BLUE_DOWN,
        SEC_BLUE_UP,
        SEC_RED_DOWN
    } t_sector;

    logic [HUE_W-1:0]    hue;
    logic [HUE_W-1:0]    base;
    logic [HUE_W-1:0]    pos;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] full_w;
    t_sector             sector;

    assign full_w = WEIGHT_W'(HUE_HALF);

    always_comb begin
        hue = (i_hue_tenths >= HUE_W'(HUE_FULL)) ? i_hue_tenths - HUE_W'(HUE_FULL)
                                                 : i_hue_tenths;
        if (hue < HUE_W'(HUE_HALF)) begin
            sector = SEC_RED_UP;
        end else if (hue < HUE_W'(2 * HUE_HALF)) begin
            sector = SEC_GREEN_DOWN;
        end else if (hue < HUE_W'(3 * HUE_HALF)) begin
            sector = SEC_GREEN_UP;
        end else if (hue < HUE_W'(4 * HUE_HALF)) begin
            sector = SEC_BLUE_DOWN;
        end else if (hue < HUE_W'(5 * HUE_HALF)) begin
            sector = SEC_BLUE_UP;
        end else begin
            sector = SEC_RED_DOWN;
        end

        if (hue < HUE_W'(HUE_PAIR)) begin
            base = '0;
        end else if (hue < HUE_W'(2 * HUE_PAIR)) begin
            base = HUE_W'(HUE_PAIR);
        end else begin
            base = HUE_W'(2 * HUE_PAIR);
        end
        pos = hue - base;
        w = (pos >= HUE_W'(HUE_HALF)) ? WEIGHT_W'(HUE_W'(HUE_PAIR) - pos) : WEIGHT_W'(pos);

        o_item.sat = i_saturation;
        o_item.val = i_value_level;
        o_item.weight = '0;
        unique case (sector)
            SEC_RED_UP: begin
                o_item.weight[CH_RED] = full_w;
                o_item.weight[CH_GREEN] = w;
            end
            SEC_GREEN_DOWN: begin
                o_item.weight[CH_RED] = w;
                o_item.weight[CH_GREEN] = full_w;
            end
            SEC_GREEN_UP: begin
                o_item.weight[CH_GREEN] = full_w;
                o_item.weight[CH_BLUE] = w;
            end
            SEC_BLUE_DOWN: begin
                o_item.weight[CH_GREEN] = w;
                o_item.weight[CH_BLUE] = full_w;
            end
            SEC_BLUE_UP: begin
                o_item.weight[CH_RED] = w;
                o_item.weight[CH_BLUE] = full_w;
            end
            SEC_RED_DOWN: begin
                o_item.weight[CH_RED] = full_w;
                o_item.weight[CH_BLUE] = w;
            end
            default: begin
                o_item.weight = '0;
            end
        endcase
    end

endmodule

### hw/rtl/hsv_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on hsv_pkg.
module hsv_queue
    import hsv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

endmodule

### hw/rtl/hsv_back.sv
// Arithmetic back end: per-channel scaling, brightness and truncating division.
// Depends on hsv_pkg; fed by hsv_queue.
module hsv_back
    import hsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_take,
    input  logic [PCT_W-1:0]  i_bright,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [23:0]       o_pixel_word
);

    logic        adv;
    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [7:0]  r_val1;
    logic [17:0] r_inner [NUM_CH];
    logic [25:0] r_prod  [NUM_CH];
    logic [32:0] r_num3  [NUM_CH];
    logic [32:0] r_num4  [NUM_CH];
    logic [9:0]  r_est   [NUM_CH];
    logic [7:0]  r_chan  [NUM_CH];
    logic [33:0] chk_prod [NUM_CH];
    logic [33:0] chk_rem  [NUM_CH];
    logic [9:0]  q_raw    [NUM_CH];
    logic [NUM_CH-1:0] est_ok;

    assign adv = !r_v5 || !i_stall;
    assign o_take = adv && i_item_valid;
    assign o_valid = r_v5;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            chk_prod[c] = 34'(r_est[c]) * 34'(CHAN_DENOM);
            chk_rem[c] = 34'(r_num4[c]) - chk_prod[c];
            q_raw[c] = (chk_rem[c] >= 34'(CHAN_DENOM)) ? r_est[c] + 1'b1 : r_est[c];
            est_ok[c] = (34'(r_num4[c]) >= chk_prod[c]) &&
                        (chk_rem[c] < 34'(2 * CHAN_DENOM));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_item_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_val1 <= i_item.val;
            for (int c = 0; c < NUM_CH; c++) begin
                r_inner[c] <= 18'(INNER_FULL) - 18'(i_item.sat) *
                              18'(WEIGHT_W'(HUE_HALF) - i_item.weight[c]);
                r_prod[c] <= 26'(r_val1) * 26'(r_inner[c]);
                r_num3[c] <= 33'(r_prod[c]) * 33'(i_bright);
                r_num4[c] <= r_num3[c];
                r_est[c] <= 10'((34'(r_num3[c] >> DROP_SHIFT) * 34'(RECIP)) >> RECIP_SHIFT);
                r_chan[c] <= (q_raw[c] > 10'd255) ? 8'd255 : q_raw[c][7:0];
            end
        end
    end

    assign o_red = r_chan[CH_RED];
    assign o_green = r_chan[CH_GREEN];
    assign o_blue = r_chan[CH_BLUE];
    assign o_pixel_word = {r_chan[CH_GREEN], r_chan[CH_RED], r_chan[CH_BLUE]};

    a_est_within_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (&est_ok))
        else $error("quotient estimate off by more than one");

    a_no_clamp_at_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && i_bright <= PCT_W'(PCT_ONE)) |->
        (q_raw[CH_RED] <= 10'd255 && q_raw[CH_GREEN] <= 10'd255 &&
         q_raw[CH_BLUE] <= 10'd255))
        else $error("channel above full scale without boost");

endmodule

### hw/rtl/hsv_to_rgb_pixel_color_top.sv
// Top level of the HSV to RGB pixel color block with global brightness.
// Depends on hsv_pkg, hsv_front, hsv_queue and hsv_back.
//
//   Channel  Handshake                  Payload
//   input    i_valid / o_stall          i_hue_tenths, i_saturation, i_value_level
//   output   o_valid / i_stall          o_red, o_green, o_blue, o_pixel_word
//   config   i_cfg_valid / o_cfg_ready  i_cfg_data (brightness percent)
//
// One pixel is taken per cycle while the queue is not full; each pixel passes through the
// queue register file and then the five-stage arithmetic pipeline.
// Reset empties the queue and pipeline and sets brightness to 100 percent.
// A stalled output holds the pipeline; the queue keeps taking input until it is full.
module hsv_to_rgb_pixel_color_top
    import hsv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [HUE_W-1:0]  i_hue_tenths,
    input  logic [FRAC_W-1:0] i_saturation,
    input  logic [FRAC_W-1:0] i_value_level,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [23:0]       o_pixel_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PCT_W-1:0]  i_cfg_data
);

    t_item            front_item;
    t_item            queue_item;
    logic             queue_full;
    logic             queue_empty;
    logic             take;
    logic [PCT_W-1:0] r_bright;

    assign o_cfg_ready = 1'b1;
    assign o_stall = queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bright <= i_cfg_data;
        end
    end

    hsv_front u_front (
        .i_hue_tenths  (i_hue_tenths),
        .i_saturation  (i_saturation),
        .i_value_level (i_value_level),
        .o_item        (front_item)
    );

    hsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !queue_full),
        .i_item  (front_item),
        .i_pop   (take),
        .o_item  (queue_item),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    hsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!queue_empty),
        .i_item       (queue_item),
        .o_take       (take),
        .i_bright     (r_bright),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_pixel_word (o_pixel_word)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hsv_to_rgb_pixel_color_top: it drives pixels over the
// stall handshake, predicts each result not known from the directed table from hue, saturation,
// value and brightness, checks them in order. Depends only on hsv_pkg and the block's RTL.
module testbench
    import hsv_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 80;
    localparam int NUM_PHASES = 6;
    localparam int DIR_COUNT = 20;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] word;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
        logic              known;
        t_rgb              rgb;
    } t_vector;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [HUE_W-1:0]  i_hue_tenths = '0;
    logic [FRAC_W-1:0] i_saturation = '0;
    logic [FRAC_W-1:0] i_value_level = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_red;
    logic [7:0]        o_green;
    logic [7:0]        o_blue;
    logic [23:0]       o_pixel_word;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PCT_W-1:0]  i_cfg_data = '0;

    t_rgb             rgb_pending [$];
    logic [PCT_W-1:0] bright_pct = BRIGHT_RESET;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               mismatch_count = 0;
    int               cycle_count = 0;
    bit               press_req = 1'b0;
    bit               press_seen = 1'b0;
    int               press_left = 0;

    // Rows with known set carry results that hold at the reset brightness of 100 percent.
    t_vector directed_vecs [DIR_COUNT] = '{
        '{12'd0,    8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   24'h000000}},
        '{12'd0,    8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0,   24'h00FF00}},
        '{12'd600,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0,   24'hFFFF00}},
        '{12'd1200, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0,   24'hFF0000}},
        '{12'd1800, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 24'hFF00FF}},
        '{12'd2400, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255, 24'h0000FF}},
        '{12'd3000, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255, 24'h00FFFF}},
        '{12'd3600, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0,   24'h00FF00}},
        '{12'd0,    8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 24'hFFFFFF}},
        '{12'd4095, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 24'hFFFFFF}},
        '{12'd4095, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   24'h000000}},
        '{12'd4095, 8'd255, 8'd255, 1'b0, '0},
        '{12'd599,  8'd255, 8'd255, 1'b0, '0},
        '{12'd1199, 8'd255, 8'd255, 1'b0, '0},
        '{12'd2999, 8'd128, 8'd200, 1'b0, '0},
        '{12'd3599, 8'd254, 8'd254, 1'b0, '0},
        '{12'd2100, 8'd1,   8'd1,   1'b0, '0},
        '{12'hAAA,  8'h55,  8'hAA,  1'b0, '0},
        '{12'h555,  8'hAA,  8'h55,  1'b0, '0},
        '{12'd300,  8'd128, 8'd128, 1'b0, '0}
    };

    int phase_len [NUM_PHASES] = '{30, 130, 130, 130, 100, 130};

    hsv_to_rgb_pixel_color_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_hue_tenths  (i_hue_tenths),
        .i_saturation  (i_saturation),
        .i_value_level (i_value_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_pixel_word  (o_pixel_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] scale_channel(input logic [FRAC_W-1:0] sat,
                                                 input logic [FRAC_W-1:0] val,
                                                 input int unsigned weight,
                                                 input logic [PCT_W-1:0] pct);
        longint unsigned num;
        longint unsigned level;
        num = longint'(val) * (longint'(sat) * weight
              + longint'(FRAC_ONE - sat) * HUE_HALF);
        level = (num * pct) / (longint'(FRAC_ONE) * HUE_HALF * PCT_ONE);
        if (level > 255) begin
            level = 255;
        end
        return level[7:0];
    endfunction

    function automatic t_rgb predict_pixel(input logic [HUE_W-1:0] hue,
                                           input logic [FRAC_W-1:0] sat,
                                           input logic [FRAC_W-1:0] val,
                                           input logic [PCT_W-1:0] pct);
        int unsigned h;
        int unsigned t;
        int unsigned w;
        int unsigned kr;
        int unsigned kg;
        int unsigned kb;
        t_rgb rgb;
        h = hue;
        if (h >= HUE_FULL) begin
            h = h - HUE_FULL;
        end
        t = h % HUE_PAIR;
        w = (t >= HUE_HALF) ? (HUE_PAIR - t) : t;
        case (h / HUE_HALF)
            0: begin kr = HUE_HALF; kg = w;        kb = 0;        end
            1: begin kr = w;        kg = HUE_HALF; kb = 0;        end
            2: begin kr = 0;        kg = HUE_HALF; kb = w;        end
            3: begin kr = 0;        kg = w;        kb = HUE_HALF; end
            4: begin kr = w;        kg = 0;        kb = HUE_HALF; end
            default: begin kr = HUE_HALF; kg = 0;  kb = w;        end
        endcase
        rgb.red = scale_channel(sat, val, kr, pct);
        rgb.green = scale_channel(sat, val, kg, pct);
        rgb.blue = scale_channel(sat, val, kb, pct);
        rgb.word = {rgb.green, rgb.red, rgb.blue};
        return rgb;
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return FRAC_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_vector random_pixel();
        t_vector vec;
        vec = '0;
        if ($urandom_range(0, 7) == 0) begin
            vec.hue = HUE_W'(HUE_HALF * $urandom_range(1, 6) - 1 + $urandom_range(0, 1));
        end else begin
            vec.hue = HUE_W'($urandom_range(0, 4095));
        end
        vec.sat = pick_fraction();
        vec.val = pick_fraction();
        return vec;
    endfunction

    task automatic send_pixel(input t_vector vec);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_hue_tenths <= vec.hue;
        i_saturation <= vec.sat;
        i_value_level <= vec.val;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (vec.known) begin
            rgb_pending.push_back(vec.rgb);
        end else begin
            rgb_pending.push_back(predict_pixel(vec.hue, vec.sat, vec.val, bright_pct));
        end
    endtask

    task automatic set_brightness(input logic [PCT_W-1:0] pct);
        i_valid <= 1'b0;
        while (rgb_pending.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data <= pct;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        bright_pct = pct;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (press_req != press_seen) begin
            press_seen = press_req;
            press_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (press_left > 0) begin
            press_left = press_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_red, o_green, o_blue, o_pixel_word};
            if (rgb_pending.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("Unexpected transfer: r %0d g %0d b %0d word %06h",
                             got.red, got.green, got.blue, got.word);
                end
            end else begin
                want = rgb_pending.pop_front();
                if (got !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display({"Mismatch: expected r %0d g %0d b %0d word %06h, ",
                                  "got r %0d g %0d b %0d word %06h"},
                                 want.red, want.green, want.blue, want.word,
                                 got.red, got.green, got.blue, got.word);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 32;
        recv_idle_pct <= 82;
        for (int i = 0; i < DIR_COUNT; i++) begin
            send_pixel(directed_vecs[i]);
        end
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_brightness(7'd0);
                1: set_brightness(7'd127);
                2: set_brightness(PCT_W'($urandom_range(1, 99)));
                3: set_brightness(7'd100);
                4: set_brightness(7'd1);
                default: set_brightness(PCT_W'($urandom_range(101, 127)));
            endcase
            if (phase < 2) begin
                send_idle_pct = 32;
                recv_idle_pct <= 82;
            end else if (phase < 4) begin
                send_idle_pct = 82;
                recv_idle_pct <= 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            // The long output hold-off makes the queue fill and stall the input.
            if (phase == 4) begin
                press_req <= ~press_req;
            end
            for (int n = 0; n < phase_len[phase]; n++) begin
                send_pixel(random_pixel());
            end
        end
        i_valid <= 1'b0;
        while (rgb_pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && rgb_pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### hsv_to_rgb_pixel_color_top.f
hw/rtl/hsv_pkg.sv
hw/rtl/hsv_front.sv
hw/rtl/hsv_queue.sv
hw/rtl/hsv_back.sv
hw/rtl/hsv_to_rgb_pixel_color_top.sv
verif/testbench.sv
